@@ design/sbda_pkg.sv @@
// Shared types and constants for the signed binary to decimal ASCII converter.
package sbda_pkg;

  localparam int VALUE_W = 64;
  localparam int DIGITS  = 19;
  localparam int IDX_W   = $clog2(DIGITS);
  localparam int CNT_W   = $clog2(VALUE_W);
  localparam int CODE_W  = 6;

  localparam logic [CODE_W-1:0] DIGIT_BASE = CODE_W'(48);
  localparam logic [CODE_W-1:0] MINUS_CODE = CODE_W'(45);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_EMIT
  } sbda_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } sbda_ctl_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic              last;
  } sbda_emit_t;

endpackage

@@ design/signed_binary_to_decimal_ascii.sv @@
// Top level: signed 64-bit integer to decimal ASCII character stream.
//
//   channel | ports                            | direction
//   input   | in_valid in_ready in_value       | one integer per transaction
//   output  | out_valid out_ready out_char_code | one character per transaction
//           | out_last_char                    |
//
// Each integer is accepted, then takes 64 shift-and-add-3 steps in the BCD
// unit and a skip over leading zero digits, then one cycle per character
// (1 to 20) while the output register drains. in_ready is high only when the
// sequencer is idle. Reset clears the sequencer and the output valid flag.
// Output stalls hold the sequencer in place; the last character may still wait
// in the output register while the next integer is accepted.
module signed_binary_to_decimal_ascii (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [sbda_pkg::VALUE_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sbda_pkg::CODE_W-1:0]  out_char_code,
  output logic                         out_last_char
);
  import sbda_pkg::*;

  sbda_ctl_t         ctl;
  sbda_emit_t        emit;
  logic [IDX_W-1:0]  digit_idx;
  logic [3:0]        digit;
  logic              out_free;
  logic              out_valid_r;
  logic [CODE_W-1:0] out_char_code_r;
  logic              out_last_char_r;

  assign out_free = !out_valid_r || out_ready;

  sbda_bcd u_bcd (
    .clk       (clk),
    .ctl       (ctl),
    .in_value  (in_value),
    .digit_idx (digit_idx),
    .digit     (digit)
  );

  sbda_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_sign   (in_value[VALUE_W-1]),
    .digit     (digit),
    .out_free  (out_free),
    .in_ready  (in_ready),
    .ctl       (ctl),
    .digit_idx (digit_idx),
    .emit      (emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_char_code_r <= emit.code;
      out_last_char_r <= emit.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_code_r;
  assign out_last_char = out_last_char_r;

endmodule

@@ design/sbda_bcd.sv @@
// Shift-and-add-3 conversion unit: one binary bit enters the BCD register per step.
module sbda_bcd (
  input  logic                        clk,
  input  sbda_pkg::sbda_ctl_t         ctl,
  input  logic [sbda_pkg::VALUE_W-1:0] in_value,
  input  logic [sbda_pkg::IDX_W-1:0]  digit_idx,
  output logic [3:0]                  digit
);
  import sbda_pkg::*;

  logic [VALUE_W-1:0]       bin_r;
  logic [VALUE_W-1:0]       bin_nxt;
  logic [DIGITS-1:0][3:0]   bcd_r;
  logic [DIGITS-1:0][3:0]   bcd_nxt;
  logic [DIGITS-1:0][3:0]   adj;
  logic [4*DIGITS-1:0]      adj_flat;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
    adj_flat = adj;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    if (ctl.load) begin
      bin_nxt = in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;
      bcd_nxt = '0;
    end else if (ctl.step) begin
      bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
      bcd_nxt = {adj_flat[4*DIGITS-2:0], bin_r[VALUE_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign digit = bcd_r[digit_idx];

endmodule

@@ design/sbda_seq.sv @@
// Sequencer: conversion steps, leading-zero skip, sign and digit emission.
module sbda_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_sign,
  input  logic [3:0]                 digit,
  input  logic                       out_free,
  output logic                       in_ready,
  output sbda_pkg::sbda_ctl_t        ctl,
  output logic [sbda_pkg::IDX_W-1:0] digit_idx,
  output sbda_pkg::sbda_emit_t       emit
);
  import sbda_pkg::*;

  sbda_state_t      state_r;
  sbda_state_t      state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic             neg_r;
  logic             neg_nxt;
  logic             idx_zero;
  logic             lead_found;

  assign idx_zero   = (idx_r == '0);
  assign lead_found = (digit != 4'd0) || idx_zero;
  assign digit_idx  = idx_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_CONV;
      S_CONV: if (cnt_r == CNT_W'(VALUE_W-1)) state_nxt = S_SKIP;
      S_SKIP: if (lead_found) state_nxt = neg_r ? S_SIGN : S_EMIT;
      S_SIGN: if (out_free) state_nxt = S_EMIT;
      S_EMIT: if (out_free && idx_zero) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    ctl        = '0;
    emit       = '0;
    emit.code  = DIGIT_BASE + CODE_W'(digit);
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      S_CONV: ctl.step = 1'b1;
      S_SKIP: ;
      S_SIGN: begin
        emit.valid = out_free;
        emit.code  = MINUS_CODE;
      end
      S_EMIT: begin
        emit.valid = out_free;
        emit.last  = idx_zero;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    neg_nxt = neg_r;
    if (ctl.load) begin
      cnt_nxt = '0;
      idx_nxt = IDX_W'(DIGITS-1);
      neg_nxt = in_sign;
    end
    if (ctl.step) cnt_nxt = cnt_r + CNT_W'(1);
    if (state_r == S_SKIP && !lead_found) idx_nxt = idx_r - IDX_W'(1);
    if (state_r == S_EMIT && out_free && !idx_zero) idx_nxt = idx_r - IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      neg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      neg_r   <= neg_nxt;
    end
  end

endmodule

@@ bench/testbench.sv @@
// Testbench for signed_binary_to_decimal_ascii: random and corner integers, text checked per char.
module testbench;
  import sbda_pkg::*;

  typedef struct {
    logic [VALUE_W-1:0] value;
    bit                 hold_for_drain;
  } number_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              last;
  } text_char_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [CODE_W-1:0]         out_char_code;
  logic                      out_last_char;

  number_t     pending_numbers[$];
  text_char_t  expected_text[$];
  logic [63:0] tens[0:19];
  int          errors = 0;
  bit          quiet = 1'b0;
  bit          sender_calm = 1'b0;
  bit          receiver_calm = 1'b0;
  int          send_gap = 0;
  int          receive_stall = 0;

  signed_binary_to_decimal_ascii u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void render_decimal(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [CODE_W-1:0]  digits[$];
    text_char_t         c;
    mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
    do begin
      digits.push_front(CODE_W'(mag % 10) + DIGIT_BASE);
      mag = mag / 10;
    end while (mag != 0);
    if (v[VALUE_W-1]) begin
      c.code = MINUS_CODE;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    foreach (digits[i]) begin
      c.code = digits[i];
      c.last = (i == digits.size() - 1);
      expected_text.push_back(c);
    end
  endfunction

  function automatic void queue_number(input logic [63:0] v, input bit drain);
    number_t n;
    n.value = v;
    n.hold_for_drain = drain;
    pending_numbers.push_back(n);
  endfunction

  function automatic logic [63:0] random_number();
    logic [63:0] mag;
    int          len;
    int          pick;
    bit          neg;
    pick = $urandom_range(0, 99);
    neg  = 1'($urandom_range(0, 1));
    if (pick < 40) begin
      mag = {$urandom, $urandom};
      return mag;
    end else if (pick < 85) begin
      len = $urandom_range(1, 19);
      mag = {$urandom, $urandom} % tens[len];
    end else begin
      len = $urandom_range(1, 19);
      mag = tens[len] + 64'($urandom_range(0, 2)) - 64'd1;
    end
    return neg ? (~mag + 64'd1) : mag;
  endfunction

  always @(posedge clk) begin
    logic        next_valid;
    logic [63:0] next_value;
    number_t     next_item;
    next_valid = in_valid;
    next_value = in_value;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        render_decimal(in_value);
        next_valid = 1'b0;
        if ($urandom_range(0, 15) == 0) sender_calm = !sender_calm;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_numbers.size() > 0) begin
          if (pending_numbers[0].hold_for_drain && expected_text.size() != 0) begin
            next_valid = 1'b0;
          end else if (!quiet && !sender_calm && $urandom_range(0, 3) == 0) begin
            send_gap = $urandom_range(0, 2);
          end else begin
            next_item  = pending_numbers.pop_front();
            next_valid = 1'b1;
            next_value = next_item.value;
          end
        end
      end
    end
    quiet    <= (pending_numbers.size() < 30);
    in_valid <= next_valid;
    in_value <= next_value;
  end

  always @(posedge clk) begin
    text_char_t want;
    logic       next_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_text.size() == 0) begin
        $error("out_char_code %0d, out_last_char %0d with no character expected",
               out_char_code, out_last_char);
        errors++;
      end else begin
        want = expected_text.pop_front();
        if (out_char_code !== want.code) begin
          $error("char_code: expected %0d, actual %0d", want.code, out_char_code);
          errors++;
        end
        if (out_last_char !== want.last) begin
          $error("last_char: expected %0d, actual %0d", want.last, out_last_char);
          errors++;
        end
      end
      if ($urandom_range(0, 40) == 0) receiver_calm = !receiver_calm;
    end
    if (!rst_n) begin
      next_ready = 1'b0;
    end else if (receive_stall > 0) begin
      receive_stall--;
      next_ready = 1'b0;
    end else if (!quiet && !receiver_calm && $urandom_range(0, 5) == 0) begin
      receive_stall = $urandom_range(0, 2);
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
    end
    out_ready <= next_ready;
  end

  initial begin
    tens[0] = 64'd1;
    for (int k = 1; k < 20; k++) tens[k] = tens[k-1] * 64'd10;

    queue_number(64'd0, 1'b0);
    queue_number(64'd1, 1'b0);
    queue_number(-64'sd1, 1'b0);
    queue_number(64'd9, 1'b0);
    queue_number(64'd10, 1'b0);
    queue_number(-64'sd10, 1'b0);
    queue_number(64'd99, 1'b0);
    queue_number(64'd100, 1'b0);
    queue_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    queue_number(64'h8000_0000_0000_0000, 1'b0);
    queue_number(64'h8000_0000_0000_0001, 1'b1);
    queue_number(-64'sd2147483648, 1'b0);
    queue_number(64'd2147483647, 1'b0);
    queue_number(-64'sd2147483649, 1'b0);
    queue_number(64'h0000_0001_0000_0000, 1'b0);
    queue_number(tens[18], 1'b0);
    queue_number(tens[18] - 64'd1, 1'b0);
    queue_number(~tens[18] + 64'd1, 1'b0);
    queue_number(64'd1234567890123456789, 1'b0);
    queue_number(64'hFFFF_FFFF_FFFF_FFF6, 1'b1);
    queue_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    queue_number(64'h5555_5555_5555_5555, 1'b0);

    for (int n = 0; n < 350; n++) begin
      queue_number(random_number(), (n % 97) == 50);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_numbers.size() != 0 || in_valid || expected_text.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
design/sbda_pkg.sv
design/sbda_bcd.sv
design/sbda_seq.sv
design/signed_binary_to_decimal_ascii.sv
bench/testbench.sv
